// File: hdl/cfr_pkg.sv
// shared types and constants of the command frame receiver
package cfr_pkg;

   // frame bytes and limits
   localparam logic [7:0] SYNC_A         = 8'hAA;
   localparam logic [7:0] SYNC_B         = 8'hAF;
   localparam logic [7:0] FN_LIMIT       = 8'hF1;
   localparam logic [7:0] LEN_LIMIT      = 8'd50;
   localparam logic [7:0] ACK_ID         = 8'hEF;
   localparam logic [7:0] FN_CMD         = 8'h02;
   localparam logic [7:0] CMD_READBACK   = 8'h01;
   localparam logic [7:0] CMD_DEFAULTS   = 8'hA1;
   localparam logic [7:0] FN_PARAM_FIRST = 8'h10;
   localparam logic [7:0] FN_PARAM_LAST  = 8'h12;
   localparam logic [7:0] FN_ACK_LAST    = 8'h15;
   // sum of the fixed ack bytes AA AA EF 02
   localparam logic [7:0] ACK_HEAD_SUM   = 8'h45;
   // store position of the first payload byte
   localparam logic [6:0] PAYLOAD_BASE   = 7'd4;
   localparam logic [3:0] LAST_WORD      = 4'd8;
   localparam logic [2:0] LAST_ACK       = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_ACK      = 2'd0;
   localparam logic [1:0] KIND_PARAM    = 2'd1;
   localparam logic [1:0] KIND_READBACK = 2'd2;
   localparam logic [1:0] KIND_DEFAULTS = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SYNC_A,
      PH_SYNC_B,
      PH_FUNC,
      PH_PAYLOAD,
      PH_CHECK
   } parse_phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FIRST_RD,
      BK_FIRST_CHK,
      BK_PARAM_RD,
      BK_PARAM_WR,
      BK_ACK
   } back_state_type;

   // a good frame handed from the parser to the action sequencer
   typedef struct packed {
      logic [7:0] fn;
      logic [7:0] sum;
   } job_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         ack_byte;
      logic [4:0]         param_index;
      logic signed [15:0] param_value;
      logic               last;
   } result_type;

endpackage

// File: hdl/cfr_fifo.sv
// small register queue used between the parser, the sequencer and the result port
module cfr_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: hdl/cfr_store.sv
// frame byte store: one write port, two registered read ports, per-entry valid bits
module cfr_store #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [7:0]               rd_data_a,
   output logic [7:0]               rd_data_b
);
   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_a_ff, rd_b_ff;
   logic             vld_a_ff, vld_b_ff;

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= valid_ff[rd_addr_a];
         vld_b_ff <= valid_ff[rd_addr_b];
      end
   end

   assign rd_data_a = vld_a_ff ? rd_a_ff : 8'd0;
   assign rd_data_b = vld_b_ff ? rd_b_ff : 8'd0;

endmodule

// File: hdl/cfr_front.sv
// frame parser: sync, header, payload capture and checksum test
module cfr_front #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [7:0]                     rx_byte,
   output logic                           full,
   input  logic                           hold,
   output logic                           wr_en,
   output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output logic                           job_push,
   output cfr_pkg::job_type               job
);
   import cfr_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   parse_phase_type phase_ff, phase_in;
   logic [5:0]      left_ff, left_in;
   logic [5:0]      taken_ff, taken_in;
   logic [7:0]      sum_ff, sum_in;
   logic [7:0]      fn_ff, fn_in;
   logic            accept;
   logic            wr_req;
   logic [6:0]      wr_pos;

   // payload bytes land where the sequencer reads, so they wait while it is busy
   assign full    = hold && (phase_ff == PH_PAYLOAD || phase_ff == PH_CHECK);
   assign accept  = push && !full;
   assign wr_en   = wr_req && (int'(wr_pos) < STORE_DEPTH);
   assign wr_addr = AW'(wr_pos);
   assign wr_data = rx_byte;
   assign job.fn  = fn_ff;
   assign job.sum = sum_ff;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      taken_in = taken_ff;
      sum_in   = sum_ff;
      fn_in    = fn_ff;
      wr_req   = 1'b0;
      wr_pos   = '0;
      job_push = 1'b0;
      if (accept) begin
         phase_in = PH_IDLE;
         case (phase_ff)
            PH_IDLE: begin
               if (rx_byte == SYNC_A) begin
                  phase_in = PH_SYNC_A;
                  wr_req   = 1'b1;
                  wr_pos   = 7'd0;
                  sum_in   = rx_byte;
               end
            end
            PH_SYNC_A: begin
               if (rx_byte == SYNC_B) begin
                  phase_in = PH_SYNC_B;
                  wr_req   = 1'b1;
                  wr_pos   = 7'd1;
                  sum_in   = sum_ff + rx_byte;
               end
            end
            PH_SYNC_B: begin
               if (rx_byte < FN_LIMIT) begin
                  phase_in = PH_FUNC;
                  wr_req   = 1'b1;
                  wr_pos   = 7'd2;
                  fn_in    = rx_byte;
                  sum_in   = sum_ff + rx_byte;
               end
            end
            PH_FUNC: begin
               if (rx_byte < LEN_LIMIT) begin
                  phase_in = PH_PAYLOAD;
                  wr_req   = 1'b1;
                  wr_pos   = 7'd3;
                  left_in  = rx_byte[5:0];
                  taken_in = '0;
                  sum_in   = sum_ff + rx_byte;
               end
            end
            PH_PAYLOAD: begin
               // zero length swallows one byte and drops to idle
               if (left_ff != '0) begin
                  wr_req   = 1'b1;
                  wr_pos   = PAYLOAD_BASE + 7'(taken_ff);
                  taken_in = taken_ff + 1'b1;
                  left_in  = left_ff - 1'b1;
                  sum_in   = sum_ff + rx_byte;
                  phase_in = (left_ff == 6'd1) ? PH_CHECK : PH_PAYLOAD;
               end
            end
            PH_CHECK: begin
               wr_req   = 1'b1;
               wr_pos   = PAYLOAD_BASE + 7'(taken_ff);
               job_push = (rx_byte == sum_ff);
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= '0;
         taken_ff <= '0;
         sum_ff   <= '0;
         fn_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         taken_ff <= taken_in;
         sum_ff   <= sum_in;
         fn_ff    <= fn_in;
      end
   end

endmodule

// File: hdl/cfr_back.sv
// action sequencer: turns a good frame into result items
module cfr_back #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_empty,
   input  cfr_pkg::job_type               job,
   output logic                           job_pop,
   output logic [$clog2(STORE_DEPTH)-1:0] rd_addr_a,
   output logic [$clog2(STORE_DEPTH)-1:0] rd_addr_b,
   input  logic [7:0]                     rd_data_a,
   input  logic [7:0]                     rd_data_b,
   output logic                           res_push,
   output cfr_pkg::result_type            res,
   input  logic                           res_full,
   output logic                           busy
);
   import cfr_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   back_state_type state_ff, state_in;
   logic [7:0]     fn_ff, fn_in;
   logic [7:0]     sum_ff, sum_in;
   logic [3:0]     word_ff, word_in;
   logic [2:0]     ack_ff, ack_in;
   logic [6:0]     hi_pos;
   logic [7:0]     ack_val;

   // word k sits at payload bytes 2k and 2k+1
   assign hi_pos    = PAYLOAD_BASE + {2'b00, word_ff, 1'b0};
   assign rd_addr_a = AW'(hi_pos);
   assign rd_addr_b = AW'(hi_pos + 7'd1);
   assign busy      = (state_ff != BK_IDLE);

   always_comb begin
      case (ack_ff)
         3'd0:    ack_val = SYNC_A;
         3'd1:    ack_val = SYNC_A;
         3'd2:    ack_val = ACK_ID;
         3'd3:    ack_val = FN_CMD;
         3'd4:    ack_val = fn_ff;
         3'd5:    ack_val = sum_ff;
         default: ack_val = ACK_HEAD_SUM + fn_ff + sum_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      fn_in    = fn_ff;
      sum_in   = sum_ff;
      word_in  = word_ff;
      ack_in   = ack_ff;
      job_pop  = 1'b0;
      res_push = 1'b0;
      res      = '0;
      case (state_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               fn_in   = job.fn;
               sum_in  = job.sum;
               word_in = '0;
               ack_in  = '0;
               if (job.fn == FN_CMD) begin
                  state_in = BK_FIRST_RD;
               end else if (job.fn >= FN_PARAM_FIRST && job.fn <= FN_PARAM_LAST) begin
                  state_in = BK_PARAM_RD;
               end else if (job.fn > FN_PARAM_LAST && job.fn <= FN_ACK_LAST) begin
                  state_in = BK_ACK;
               end
            end
         end
         BK_FIRST_RD: begin
            state_in = BK_FIRST_CHK;
         end
         BK_FIRST_CHK: begin
            res.last = 1'b1;
            if (rd_data_a == CMD_READBACK) begin
               res.kind = KIND_READBACK;
               res_push = !res_full;
               if (!res_full) begin
                  state_in = BK_IDLE;
               end
            end else if (rd_data_a == CMD_DEFAULTS) begin
               res.kind = KIND_DEFAULTS;
               res_push = !res_full;
               if (!res_full) begin
                  state_in = BK_IDLE;
               end
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_PARAM_RD: begin
            state_in = BK_PARAM_WR;
         end
         BK_PARAM_WR: begin
            res.kind        = KIND_PARAM;
            res.param_index = 5'(fn_ff[1:0]) * 5'd9 + 5'(word_ff);
            res.param_value = {rd_data_a, rd_data_b};
            res_push        = !res_full;
            if (!res_full) begin
               if (word_ff == LAST_WORD) begin
                  state_in = BK_ACK;
               end else begin
                  word_in  = word_ff + 1'b1;
                  state_in = BK_PARAM_RD;
               end
            end
         end
         BK_ACK: begin
            res.kind     = KIND_ACK;
            res.ack_byte = ack_val;
            res.last     = (ack_ff == LAST_ACK);
            res_push     = !res_full;
            if (!res_full) begin
               if (ack_ff == LAST_ACK) begin
                  state_in = BK_IDLE;
               end else begin
                  ack_in = ack_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      fn_ff   <= fn_in;
      sum_ff  <= sum_in;
      word_ff <= word_in;
      ack_ff  <= ack_in;
   end

endmodule

// File: hdl/command_frame_receiver.sv
// command frame receiver: byte parser, frame store, action sequencer and result queue
// throughput: one byte per cycle; payload and checksum bytes wait while a frame is acted on
// after the checksum byte, ack-only frames go straight to their ack items, the rest first
// wait on a registered store read; a parameter frame gives 16 items, a store read and a
// write state per word, and waits while the result queue stays full
// reset: synchronous, clears parser, queues and store valid bits directly, no clearing pass
module command_frame_receiver #(
   parameter int STORE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_ack_byte,
   output logic [4:0]  rsp_param_index,
   output logic signed [15:0] rsp_param_value,
   output logic        rsp_last
);
   import cfr_pkg::*;

   localparam int AW      = $clog2(STORE_DEPTH);
   localparam int JOB_W   = $bits(job_type);
   localparam int RES_W   = $bits(result_type);

   // parser to store
   logic          st_wr_en;
   logic [AW-1:0] st_wr_addr;
   logic [7:0]    st_wr_data;
   // sequencer to store
   logic [AW-1:0] st_rd_addr_a, st_rd_addr_b;
   logic [7:0]    st_rd_data_a, st_rd_data_b;
   // job queue between the two halves
   logic          job_push, job_pop, job_full, job_empty;
   job_type       job_in, job_out;
   logic [JOB_W-1:0] job_dout;
   // result queue
   logic          res_push, res_full;
   result_type    res_in, res_out;
   logic [RES_W-1:0] res_dout;
   // sequencer busy or a frame waiting for it
   logic          back_busy;
   logic          hold;

   assign hold = back_busy || !job_empty;

   // front: sync hunt, header checks, payload capture, checksum
   cfr_front #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .rx_byte  (req_rx_byte),
      .full     (full),
      .hold     (hold),
      .wr_en    (st_wr_en),
      .wr_addr  (st_wr_addr),
      .wr_data  (st_wr_data),
      .job_push (job_push),
      .job      (job_in)
   );

   // frame byte store, byte i of the frame at address i
   cfr_store #(
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (st_wr_en),
      .wr_addr   (st_wr_addr),
      .wr_data   (st_wr_data),
      .rd_addr_a (st_rd_addr_a),
      .rd_addr_b (st_rd_addr_b),
      .rd_data_a (st_rd_data_a),
      .rd_data_b (st_rd_data_b)
   );

   // good frames waiting for the sequencer
   cfr_fifo #(
      .WIDTH(JOB_W),
      .DEPTH(2)
   ) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (job_dout),
      .empty (job_empty)
   );

   assign job_out = job_type'(job_dout);

   // back: reads parameter words, decodes commands and builds the ack frame
   cfr_back #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_out),
      .job_pop   (job_pop),
      .rd_addr_a (st_rd_addr_a),
      .rd_addr_b (st_rd_addr_b),
      .rd_data_a (st_rd_data_a),
      .rd_data_b (st_rd_data_b),
      .res_push  (res_push),
      .res       (res_in),
      .res_full  (res_full),
      .busy      (back_busy)
   );

   // result items wait here until popped
   cfr_fifo #(
      .WIDTH(RES_W),
      .DEPTH(4)
   ) u_res_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res_in),
      .full  (res_full),
      .pop   (pop),
      .dout  (res_dout),
      .empty (empty)
   );

   assign res_out         = result_type'(res_dout);
   assign rsp_out_kind    = res_out.kind;
   assign rsp_ack_byte    = res_out.ack_byte;
   assign rsp_param_index = res_out.param_index;
   assign rsp_param_value = res_out.param_value;
   assign rsp_last        = res_out.last;

   // payload bytes never overwrite the store while a frame is being acted on
   assert property (@(posedge clock) disable iff (reset)
      (st_wr_en && st_wr_addr >= AW'(PAYLOAD_BASE)) |-> !hold)
      else $error("payload write while sequencer reads the store");

   // at most one good frame is ever queued
   assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job_empty && !job_full))
      else $error("good frame while another is pending");

   // the sequencer only pushes into a result queue with room
   assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");

endmodule

// File: tb/command_frame_receiver_checker.sv
// predictor and scoreboard for the command frame receiver result items
`timescale 1ns / 100ps
module command_frame_receiver_checker #(
   parameter int STORE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic        empty,
   input  logic        pop,
   input  logic [1:0]  rsp_out_kind,
   input  logic [7:0]  rsp_ack_byte,
   input  logic [4:0]  rsp_param_index,
   input  logic signed [15:0] rsp_param_value,
   input  logic        rsp_last,
   output int          mismatches,
   output int          results_pending
);
   import cfr_pkg::*;

   localparam int WORDS_PER_FRAME = 9;
   localparam int ACK_LEN         = 7;

   parse_phase_type phase;
   logic [5:0]      payload_left;
   logic [5:0]      payload_taken;
   logic [7:0]      frame_sum;
   logic [7:0]      frame_fn;
   logic [7:0]      frame_store [STORE_DEPTH];
   result_type      frame_actions_due [$];

   task automatic queue_result(input logic [1:0] kind, input logic [7:0] ack,
                               input logic [4:0] slot, input logic [15:0] value);
      result_type r;
      r.kind        = kind;
      r.ack_byte    = ack;
      r.param_index = slot;
      r.param_value = value;
      r.last        = 1'b0;
      frame_actions_due.push_back(r);
   endtask

   // advance the parser by one byte and queue whatever a good frame asks for
   task automatic parse_rx_byte(input logic [7:0] b);
      int         first_new;
      int         pos;
      int         k;
      logic [7:0] ack_bytes [ACK_LEN];
      result_type tail;
      first_new = frame_actions_due.size();
      if (phase == PH_IDLE && b == SYNC_A) begin
         phase          = PH_SYNC_A;
         frame_store[0] = b;
         frame_sum      = b;
      end else if (phase == PH_SYNC_A && b == SYNC_B) begin
         phase          = PH_SYNC_B;
         frame_store[1] = b;
         frame_sum      = frame_sum + b;
      end else if (phase == PH_SYNC_B && b < FN_LIMIT) begin
         phase          = PH_FUNC;
         frame_store[2] = b;
         frame_fn       = b;
         frame_sum      = frame_sum + b;
      end else if (phase == PH_FUNC && b < LEN_LIMIT) begin
         phase          = PH_PAYLOAD;
         frame_store[3] = b;
         payload_left   = b[5:0];
         payload_taken  = '0;
         frame_sum      = frame_sum + b;
      end else if (phase == PH_PAYLOAD && payload_left != 0) begin
         pos = PAYLOAD_BASE + payload_taken;
         if (pos < STORE_DEPTH) frame_store[pos] = b;
         payload_taken = payload_taken + 1'b1;
         payload_left  = payload_left - 1'b1;
         frame_sum     = frame_sum + b;
         if (payload_left == 0) phase = PH_CHECK;
      end else if (phase == PH_CHECK) begin
         phase = PH_IDLE;
         // checksum byte lands in the store too, short frames read it back
         pos = PAYLOAD_BASE + payload_taken;
         if (pos < STORE_DEPTH) frame_store[pos] = b;
         if (b == frame_sum) begin
            if (frame_fn == FN_CMD) begin
               if (frame_store[PAYLOAD_BASE] == CMD_READBACK)
                  queue_result(KIND_READBACK, '0, '0, '0);
               else if (frame_store[PAYLOAD_BASE] == CMD_DEFAULTS)
                  queue_result(KIND_DEFAULTS, '0, '0, '0);
            end else if (frame_fn >= FN_PARAM_FIRST && frame_fn <= FN_ACK_LAST) begin
               if (frame_fn <= FN_PARAM_LAST) begin
                  for (k = 0; k < WORDS_PER_FRAME; k++)
                     queue_result(KIND_PARAM, '0,
                                  5'((frame_fn - FN_PARAM_FIRST) * WORDS_PER_FRAME + k),
                                  {frame_store[PAYLOAD_BASE + 2 * k],
                                   frame_store[PAYLOAD_BASE + 2 * k + 1]});
               end
               ack_bytes[0] = SYNC_A;
               ack_bytes[1] = SYNC_A;
               ack_bytes[2] = ACK_ID;
               ack_bytes[3] = FN_CMD;
               ack_bytes[4] = frame_fn;
               ack_bytes[5] = frame_sum;
               ack_bytes[6] = '0;
               for (k = 0; k < ACK_LEN - 1; k++)
                  ack_bytes[ACK_LEN - 1] = ack_bytes[ACK_LEN - 1] + ack_bytes[k];
               for (k = 0; k < ACK_LEN; k++)
                  queue_result(KIND_ACK, ack_bytes[k], '0, '0);
            end
         end
      end else begin
         phase = PH_IDLE;
      end
      if (frame_actions_due.size() > first_new) begin
         tail      = frame_actions_due.pop_back();
         tail.last = 1'b1;
         frame_actions_due.push_back(tail);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got, inout bit bad);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      bit         bad;
      if (reset) begin
         phase         = PH_IDLE;
         payload_left  = '0;
         payload_taken = '0;
         frame_sum     = '0;
         frame_fn      = '0;
         for (int i = 0; i < STORE_DEPTH; i++) frame_store[i] = '0;
         frame_actions_due.delete();
         mismatches    = 0;
      end else begin
         if (pop && !empty) begin
            if (frame_actions_due.size() == 0) begin
               $display("%0t: unexpected item, expected none, got kind %0h ack %0h index %0h",
                        $time, rsp_out_kind, rsp_ack_byte, rsp_param_index);
               mismatches++;
            end else begin
               want = frame_actions_due.pop_front();
               bad  = 1'b0;
               check_field("out_kind", want.kind, rsp_out_kind, bad);
               check_field("ack_byte", want.ack_byte, rsp_ack_byte, bad);
               check_field("param_index", want.param_index, rsp_param_index, bad);
               check_field("param_value", want.param_value, rsp_param_value, bad);
               check_field("last", want.last, rsp_last, bad);
               if (bad) mismatches++;
            end
         end
         if (push && !full) parse_rx_byte(req_rx_byte);
      end
      results_pending = frame_actions_due.size();
   end

endmodule

// File: tb/command_frame_receiver_tb.sv
// top of the command frame receiver testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps
module command_frame_receiver_tb;
   import cfr_pkg::*;

   localparam int  HOLD_CYCLES   = 400;      // long receiver hold-off to fill the block
   localparam int  MIX_BYTES     = 25;       // bytes of random frames and noise
   localparam int  DRAIN_CYCLES  = 64;       // settle time once nothing is outstanding
   localparam int  MAX_LEN       = 63;       // largest value a broken length byte takes here
   localparam int  TIMEOUT_NS    = 2_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_rx_byte;
   logic        empty;
   logic        pop;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_ack_byte;
   logic [4:0]  rsp_param_index;
   logic signed [15:0] rsp_param_value;
   logic        rsp_last;

   int mismatches;
   int results_pending;
   int bytes_sent;

   // idling switches, cleared for the closing stretch of the run
   bit sender_idles;
   bit receiver_idles;
   // raised by the stimulus, dropped by the receiver process once the hold-off is over
   bit hold_results;

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   command_frame_receiver dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_rx_byte     (req_rx_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_ack_byte    (rsp_ack_byte),
      .rsp_param_index (rsp_param_index),
      .rsp_param_value (rsp_param_value),
      .rsp_last        (rsp_last)
   );

   command_frame_receiver_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_rx_byte     (req_rx_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_ack_byte    (rsp_ack_byte),
      .rsp_param_index (rsp_param_index),
      .rsp_param_value (rsp_param_value),
      .rsp_last        (rsp_last),
      .mismatches      (mismatches),
      .results_pending (results_pending)
   );

   // offer one byte, possibly after an idle burst, and return at the edge that takes it
   task automatic send_byte(input logic [7:0] b);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
   endtask

   // build AA AF fn len payload checksum; lead forces the first payload byte when
   // not negative, sum_ok clear spoils the checksum, cut keeps only that many bytes
   task automatic send_frame(input logic [7:0] fn, input int len, input int lead,
                             input bit sum_ok, input int cut);
      logic [7:0] frame_bytes [$];
      logic [7:0] sum;
      logic [7:0] b;
      int         n;
      frame_bytes.push_back(SYNC_A);
      frame_bytes.push_back(SYNC_B);
      frame_bytes.push_back(fn);
      frame_bytes.push_back(8'(len));
      for (n = 0; n < len; n++) begin
         b = (n == 0 && lead >= 0) ? 8'(lead) : 8'($urandom);
         frame_bytes.push_back(b);
      end
      sum = '0;
      foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
      if (!sum_ok) sum = sum + 8'($urandom_range(1, 255));
      frame_bytes.push_back(sum);
      n = (cut >= 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
      for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
   endtask

   // mostly well-formed frames with random content, the rest broken frames and noise
   task automatic send_random_frame();
      int         pick;
      logic [7:0] fn;
      int         len;
      int         lead;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         // parameter frames, mostly full length, some short so stale bytes are read
         fn  = FN_PARAM_FIRST + 8'($urandom_range(0, 2));
         len = ($urandom_range(0, 9) < 7) ? 18 : $urandom_range(1, LEN_LIMIT - 1);
         send_frame(fn, len, -1, 1'b1, -1);
      end else if (pick < 55) begin
         // acknowledge-only functions
         fn = FN_PARAM_LAST + 8'($urandom_range(1, 3));
         send_frame(fn, $urandom_range(1, 20), -1, 1'b1, -1);
      end else if (pick < 65) begin
         case ($urandom_range(0, 2))
            0: lead = CMD_READBACK;
            1: lead = CMD_DEFAULTS;
            default: lead = $urandom_range(0, 255);
         endcase
         send_frame(FN_CMD, $urandom_range(1, 6), lead, 1'b1, -1);
      end else if (pick < 72) begin
         // any legal function byte, most of them do nothing
         fn = 8'($urandom_range(0, FN_LIMIT - 1));
         send_frame(fn, $urandom_range(1, 8), -1, 1'b1, -1);
      end else if (pick < 78) begin
         // bad checksum
         fn = FN_PARAM_FIRST + 8'($urandom_range(0, 5));
         send_frame(fn, $urandom_range(1, 18), -1, 1'b0, -1);
      end else if (pick < 83) begin
         // zero length, the checksum byte gets swallowed
         fn = 8'($urandom_range(0, FN_LIMIT - 1));
         send_frame(fn, 0, -1, 1'b1, -1);
      end else if (pick < 87) begin
         // length byte out of range
         fn = FN_PARAM_FIRST + 8'($urandom_range(0, 2));
         send_frame(fn, $urandom_range(LEN_LIMIT, MAX_LEN), -1, 1'b1, -1);
      end else if (pick < 91) begin
         // function byte out of range
         fn = 8'($urandom_range(FN_LIMIT, 255));
         send_frame(fn, $urandom_range(1, 8), -1, 1'b1, -1);
      end else if (pick < 95) begin
         // frame cut short, whatever follows breaks it
         fn = FN_PARAM_FIRST + 8'($urandom_range(0, 2));
         send_frame(fn, 18, -1, 1'b1, $urandom_range(1, 21));
      end else begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
   endtask

   // receiver: pop high most of the time, random stall bursts, one long hold-off
   initial begin
      pop = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_results) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      int mix_start;
      reset          = 1'b1;
      push           = 1'b0;
      req_rx_byte    = '0;
      bytes_sent     = 0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_results   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero length frame; the byte after the length is swallowed even though it is AA
      send_frame(FN_PARAM_FIRST, 0, -1, 1'b1, 4);
      send_byte(SYNC_A);
      // AA then AA: the second one only drops the parser to idle
      send_byte(SYNC_A);
      send_byte(SYNC_A);
      // readback and restore-defaults commands
      send_frame(FN_CMD, 1, CMD_READBACK, 1'b1, -1);
      send_frame(FN_CMD, 1, CMD_DEFAULTS, 1'b1, -1);
      // one-byte parameter frame: words past the payload come from the store as it stands
      send_frame(FN_PARAM_FIRST + 8'd1, 1, 8'hFF, 1'b1, -1);
      // highest acknowledge-only function, payload starting at zero
      send_frame(FN_ACK_LAST, 2, 0, 1'b1, -1);

      // receiver holds off while full parameter frames keep coming, so the block backs up
      hold_results = 1'b1;
      repeat (2) send_frame(FN_PARAM_FIRST + 8'($urandom_range(0, 2)), 18, -1, 1'b1, -1);

      // random mix, with no idling in the final quarter
      mix_start = bytes_sent;
      while (bytes_sent - mix_start < MIX_BYTES) begin
         if (bytes_sent - mix_start > MIX_BYTES * 3 / 4) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         send_random_frame();
      end
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      push <= 1'b0;

      // wait for every predicted item, then let the block settle
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && results_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: command_frame_receiver.f
hdl/cfr_pkg.sv
hdl/cfr_fifo.sv
hdl/cfr_store.sv
hdl/cfr_front.sv
hdl/cfr_back.sv
hdl/command_frame_receiver.sv
tb/command_frame_receiver_checker.sv
tb/command_frame_receiver_tb.sv
